### rtl/gzhf_pkg.sv
// Package for the gzip member header and footer parser.
// Holds the parse phases, status codes, flag masks and the structs passed between modules.
// No dependencies.
`default_nettype none

package gzhf_pkg;

  typedef enum logic [3:0] {
    PH_MAG0  = 4'd0,
    PH_MAG1  = 4'd1,
    PH_FIXED = 4'd2,
    PH_XLEN  = 4'd3,
    PH_XDATA = 4'd4,
    PH_NAME  = 4'd5,
    PH_CMT   = 4'd6,
    PH_HCRC  = 4'd7,
    PH_DATA  = 4'd8,
    PH_BAD   = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_TRUNC     = 2'd2
  } status_t;

  localparam logic [7:0] MAGIC0 = 8'h1f;
  localparam logic [7:0] MAGIC1 = 8'h8b;

  localparam logic [7:0] FLG_CRC16   = 8'h02;
  localparam logic [7:0] FLG_EXTRA   = 8'h04;
  localparam logic [7:0] FLG_NAME    = 8'h08;
  localparam logic [7:0] FLG_COMMENT = 8'h10;

  localparam logic [15:0] FIXED_FLAG_POS  = 16'd3;
  localparam logic [15:0] FIXED_STAMP_LO  = 16'd4;
  localparam logic [15:0] FIXED_STAMP_HI  = 16'd7;
  localparam logic [15:0] FIXED_LAST_POS  = 16'd9;
  localparam logic [15:0] FIXED_START_POS = 16'd2;

  localparam int WIN_DEPTH = 8;
  localparam int FILL_W    = $clog2(WIN_DEPTH + 1);

  typedef struct packed {
    logic        data_phase;
    logic        bad_magic;
    logic [31:0] mod_time;
    logic [15:0] extra_length;
    logic [31:0] header_length;
  } hdr_info_t;

  typedef struct packed {
    logic        pvalid;
    logic [7:0]  pbyte;
    logic        full_next;
    logic [31:0] crc;
    logic [31:0] size;
  } win_info_t;

  // First flagged optional section at or after the given phase, else the data phase.
  function automatic phase_t next_section(input phase_t from, input logic [7:0] flags);
    phase_t res;
    if (from <= PH_XLEN && (flags & FLG_EXTRA) != 8'h00) begin
      res = PH_XLEN;
    end else if (from <= PH_NAME && (flags & FLG_NAME) != 8'h00) begin
      res = PH_NAME;
    end else if (from <= PH_CMT && (flags & FLG_COMMENT) != 8'h00) begin
      res = PH_CMT;
    end else if (from <= PH_HCRC && (flags & FLG_CRC16) != 8'h00) begin
      res = PH_HCRC;
    end else begin
      res = PH_DATA;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/gzhf_hdr.sv
// Header walker: phase state machine, field counter, flags, timestamp and extra length.
// Depends on gzhf_pkg.
`default_nettype none

module gzhf_hdr (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_last,
  output gzhf_pkg::hdr_info_t     info
);

  gzhf_pkg::phase_t phase, phase_next;
  logic [15:0] field_counter, field_counter_next;
  logic [7:0]  flag_bits, flag_bits_next;
  logic [31:0] stamp_reg, stamp_reg_next;
  logic [15:0] extra_len_reg, extra_len_reg_next;
  logic [31:0] offset_count, offset_count_next;
  logic [15:0] xlen_full;
  logic [15:0] xcount;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= gzhf_pkg::PH_MAG0;
      field_counter <= '0;
      flag_bits     <= '0;
      stamp_reg     <= '0;
      extra_len_reg <= '0;
      offset_count  <= '0;
    end else begin
      phase         <= phase_next;
      field_counter <= field_counter_next;
      flag_bits     <= flag_bits_next;
      stamp_reg     <= stamp_reg_next;
      extra_len_reg <= extra_len_reg_next;
      offset_count  <= offset_count_next;
    end
  end

  assign xlen_full = {in_byte, extra_len_reg[7:0]};
  assign xcount    = field_counter + 16'd1;

  always_comb begin
    phase_next         = phase;
    field_counter_next = field_counter;
    flag_bits_next     = flag_bits;
    stamp_reg_next     = stamp_reg;
    extra_len_reg_next = extra_len_reg;
    offset_count_next  = offset_count;
    if (step) begin
      if (phase < gzhf_pkg::PH_DATA && offset_count != '1) begin
        offset_count_next = offset_count + 32'd1;
      end
      case (phase)
        gzhf_pkg::PH_MAG0: begin
          field_counter_next = '0;
          phase_next = (in_byte == gzhf_pkg::MAGIC0) ? gzhf_pkg::PH_MAG1 : gzhf_pkg::PH_BAD;
        end
        gzhf_pkg::PH_MAG1: begin
          if (in_byte == gzhf_pkg::MAGIC1) begin
            phase_next         = gzhf_pkg::PH_FIXED;
            field_counter_next = gzhf_pkg::FIXED_START_POS;
          end else begin
            phase_next         = gzhf_pkg::PH_BAD;
            field_counter_next = '0;
          end
        end
        gzhf_pkg::PH_FIXED: begin
          if (field_counter == gzhf_pkg::FIXED_FLAG_POS) begin
            flag_bits_next = in_byte;
          end else if (field_counter >= gzhf_pkg::FIXED_STAMP_LO &&
                       field_counter <= gzhf_pkg::FIXED_STAMP_HI) begin
            stamp_reg_next[{field_counter[1:0], 3'b000} +: 8] = in_byte;
          end
          if (field_counter >= gzhf_pkg::FIXED_LAST_POS) begin
            phase_next         = gzhf_pkg::next_section(gzhf_pkg::PH_XLEN, flag_bits);
            field_counter_next = '0;
          end else begin
            field_counter_next = xcount;
          end
        end
        gzhf_pkg::PH_XLEN: begin
          if (field_counter == '0) begin
            extra_len_reg_next = {8'h00, in_byte};
            field_counter_next = 16'd1;
          end else begin
            extra_len_reg_next = xlen_full;
            field_counter_next = '0;
            phase_next = (xlen_full == '0) ?
                         gzhf_pkg::next_section(gzhf_pkg::PH_NAME, flag_bits) :
                         gzhf_pkg::PH_XDATA;
          end
        end
        gzhf_pkg::PH_XDATA: begin
          field_counter_next = xcount;
          if (xcount >= extra_len_reg) begin
            phase_next         = gzhf_pkg::next_section(gzhf_pkg::PH_NAME, flag_bits);
            field_counter_next = '0;
          end
        end
        gzhf_pkg::PH_NAME: begin
          if (in_byte == 8'h00) begin
            phase_next         = gzhf_pkg::next_section(gzhf_pkg::PH_CMT, flag_bits);
            field_counter_next = '0;
          end
        end
        gzhf_pkg::PH_CMT: begin
          if (in_byte == 8'h00) begin
            phase_next         = gzhf_pkg::next_section(gzhf_pkg::PH_HCRC, flag_bits);
            field_counter_next = '0;
          end
        end
        gzhf_pkg::PH_HCRC: begin
          if (field_counter == '0) begin
            field_counter_next = 16'd1;
          end else begin
            phase_next         = gzhf_pkg::PH_DATA;
            field_counter_next = '0;
          end
        end
        default: begin
        end
      endcase
      if (in_last) begin
        phase_next         = gzhf_pkg::PH_MAG0;
        field_counter_next = '0;
        flag_bits_next     = '0;
        stamp_reg_next     = '0;
        extra_len_reg_next = '0;
        offset_count_next  = '0;
      end
    end
  end

  always_comb begin
    info.data_phase    = (phase == gzhf_pkg::PH_DATA);
    info.bad_magic     = (phase == gzhf_pkg::PH_BAD) ||
                         (phase == gzhf_pkg::PH_MAG0 && in_byte != gzhf_pkg::MAGIC0) ||
                         (phase == gzhf_pkg::PH_MAG1 && in_byte != gzhf_pkg::MAGIC1);
    info.mod_time      = stamp_reg;
    info.extra_length  = extra_len_reg;
    info.header_length = offset_count;
  end

endmodule

`default_nettype wire

### rtl/gzhf_win.sv
// Eight-byte delay window that holds back the footer and releases payload bytes.
// Depends on gzhf_pkg.
`default_nettype none

module gzhf_win (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic               data_phase,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_last,
  output gzhf_pkg::win_info_t     info
);

  logic [7:0] win [gzhf_pkg::WIN_DEPTH];
  logic [gzhf_pkg::FILL_W-1:0] fill, fill_next;
  logic full;
  logic shift;

  assign full  = (fill == gzhf_pkg::FILL_W'(gzhf_pkg::WIN_DEPTH));
  assign shift = step && data_phase;

  always_comb begin
    fill_next = fill;
    if (shift && !full) begin
      fill_next = fill + gzhf_pkg::FILL_W'(1);
    end
    if (step && in_last) begin
      fill_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  // The window always shifts toward entry zero; once full, entry zero is the oldest byte.
  always_ff @(posedge clk) begin
    if (shift) begin
      for (int i = 0; i < gzhf_pkg::WIN_DEPTH - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[gzhf_pkg::WIN_DEPTH-1] <= in_byte;
    end
  end

  always_comb begin
    info.pvalid    = shift && full;
    info.pbyte     = win[0];
    info.full_next = full || (fill == gzhf_pkg::FILL_W'(gzhf_pkg::WIN_DEPTH - 1));
    info.crc       = {win[4], win[3], win[2], win[1]};
    info.size      = {in_byte, win[7], win[6], win[5]};
  end

endmodule

`default_nettype wire

### rtl/gzip_header_footer_parser.sv
// Top level of the gzip member header and footer parser, with the result register.
// Depends on gzhf_pkg, gzhf_hdr and gzhf_win.
// Output: a result is registered and appears on the outputs in the cycle after its input byte is accepted.
// Throughput: one byte per cycle while out_ready is high; a new byte is taken while the result register drains.
// Reset: synchronous; the parser returns to the first magic byte with an empty window.
// The same state is restored after every byte that carries in_last.
`default_nettype none

module gzip_header_footer_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [7:0]  payload_byte,
  output      logic        payload_valid,
  output      logic        member_done,
  output      logic [1:0]  parse_status,
  output      logic [31:0] mod_time,
  output      logic [15:0] extra_length,
  output      logic [31:0] header_length,
  output      logic [31:0] data_crc,
  output      logic [31:0] plain_size
);

  gzhf_pkg::hdr_info_t hdr;
  gzhf_pkg::win_info_t win;
  logic step;
  logic emit;
  logic ok;
  gzhf_pkg::status_t status;

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  gzhf_hdr u_hdr (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (in_byte),
    .in_last (in_last),
    .info    (hdr)
  );

  gzhf_win u_win (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_phase (hdr.data_phase),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .info       (win)
  );

  assign emit = step && (win.pvalid || in_last);
  assign ok   = in_last && !hdr.bad_magic && hdr.data_phase && win.full_next;

  always_comb begin
    if (!in_last) begin
      status = gzhf_pkg::ST_OK;
    end else if (hdr.bad_magic) begin
      status = gzhf_pkg::ST_BAD_MAGIC;
    end else if (ok) begin
      status = gzhf_pkg::ST_OK;
    end else begin
      status = gzhf_pkg::ST_TRUNC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      payload_byte  <= win.pvalid ? win.pbyte : 8'h00;
      payload_valid <= win.pvalid;
      member_done   <= in_last;
      parse_status  <= status;
      mod_time      <= ok ? hdr.mod_time : 32'h0;
      extra_length  <= ok ? hdr.extra_length : 16'h0;
      header_length <= ok ? hdr.header_length : 32'h0;
      data_crc      <= ok ? win.crc : 32'h0;
      plain_size    <= ok ? win.size : 32'h0;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result register not empty after reset");

  a_no_payload_outside_data: assert property (@(posedge clk) disable iff (rst)
    !hdr.data_phase |-> !win.pvalid)
    else $error("payload released outside the data phase");

  a_payload_last_is_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && payload_valid && member_done |-> parse_status == gzhf_pkg::ST_OK)
    else $error("payload emitted with a failing status");

  a_fields_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && member_done && parse_status != gzhf_pkg::ST_OK |->
      mod_time == 32'h0 && extra_length == 16'h0 && data_crc == 32'h0)
    else $error("summary fields not cleared on a failing status");

endmodule

`default_nettype wire
